### src/rttfc_pkg.sv
// rttfc_pkg: types, register codes, reset values and helpers for the RTT flow control block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
package rttfc_pkg;

	localparam int unsigned TIME_W     = 16;
	localparam int unsigned RATE_W     = 8;
	localparam int unsigned TIMER_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RTT_THRESHOLD   = 3'd0,
		REG_GOOD_RATE       = 3'd1,
		REG_BAD_RATE        = 3'd2,
		REG_PENALTY_INITIAL = 3'd3,
		REG_PENALTY_MIN     = 3'd4,
		REG_PENALTY_MAX     = 3'd5,
		REG_HOLD            = 3'd6
	} cfg_reg_t;

	localparam logic [TIME_W-1:0] RST_RTT_THRESHOLD   = 16'd250;
	localparam logic [RATE_W-1:0] RST_GOOD_RATE       = 8'd30;
	localparam logic [RATE_W-1:0] RST_BAD_RATE        = 8'd10;
	localparam logic [TIME_W-1:0] RST_PENALTY_INITIAL = 16'd4000;
	localparam logic [TIME_W-1:0] RST_PENALTY_MIN     = 16'd1000;
	localparam logic [TIME_W-1:0] RST_PENALTY_MAX     = 16'd60000;
	localparam logic [TIME_W-1:0] RST_HOLD            = 16'd10000;

	typedef struct packed {
		logic [TIME_W-1:0] rtt_threshold_ms;
		logic [RATE_W-1:0] good_rate;
		logic [RATE_W-1:0] bad_rate;
		logic [TIME_W-1:0] penalty_initial_ms;
		logic [TIME_W-1:0] penalty_min_ms;
		logic [TIME_W-1:0] penalty_max_ms;
		logic [TIME_W-1:0] hold_ms;
	} cfg_t;

	typedef struct packed {
		logic               mode_good;
		logic [TIME_W-1:0]  penalty_ms;
		logic [TIMER_W-1:0] good_time_ms;
		logic [TIMER_W-1:0] reduce_time_ms;
	} state_t;

	// timer plus tick, stuck at all ones on overflow
	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIMER_W:0] s;
		s = {1'b0, a} + {{(TIMER_W+1-TIME_W){1'b0}}, b};
		sat_add = s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
	endfunction

endpackage

### src/rttfc_if.sv
// rttfc interfaces: tick input channel, result channel and register write channel.
// Depends on rttfc_pkg.
`timescale 1ns / 1ps
interface rttfc_tick_if;
	logic                        valid;
	logic                        ready;
	logic [rttfc_pkg::TIME_W-1:0] tick_ms;
	logic [rttfc_pkg::TIME_W-1:0] rtt_ms;
	modport source (output valid, output tick_ms, output rtt_ms, input ready);
	modport sink   (input valid, input tick_ms, input rtt_ms, output ready);
endinterface

interface rttfc_res_if;
	logic                        valid;
	logic                        ready;
	logic                        good_mode;
	logic [rttfc_pkg::RATE_W-1:0] send_rate;
	modport source (output valid, output good_mode, output send_rate, input ready);
	modport sink   (input valid, input good_mode, input send_rate, output ready);
endinterface

interface rttfc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rttfc_pkg::CFG_IDX_W-1:0]  index;
	logic [rttfc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### src/rttfc_core.sv
// rttfc_core: next-state logic for one tick (mode, penalty and both timers).
// Depends on rttfc_pkg.
`timescale 1ns / 1ps
module rttfc_core (
	input  rttfc_pkg::cfg_t              cfg,
	input  rttfc_pkg::state_t            cur,
	input  logic [rttfc_pkg::TIME_W-1:0] tick_ms,
	input  logic [rttfc_pkg::TIME_W-1:0] rtt_ms,
	output rttfc_pkg::state_t            nxt
);
	import rttfc_pkg::*;

	logic               bad_rtt;
	logic [TIMER_W-1:0] good_inc;
	logic [TIMER_W-1:0] red_inc;
	logic [TIMER_W-1:0] good_bad_mode;
	logic [TIME_W:0]    dbl;
	logic [TIME_W-1:0]  half;
	logic [TIMER_W-1:0] hold_w;
	logic [TIMER_W-1:0] pen_w;

	assign bad_rtt  = rtt_ms > cfg.rtt_threshold_ms;
	assign good_inc = sat_add(cur.good_time_ms, tick_ms);
	assign red_inc  = sat_add(cur.reduce_time_ms, tick_ms);
	assign dbl      = {cur.penalty_ms, 1'b0};
	assign half     = {1'b0, cur.penalty_ms[TIME_W-1:1]};
	assign hold_w   = {{(TIMER_W-TIME_W){1'b0}}, cfg.hold_ms};
	assign pen_w    = {{(TIMER_W-TIME_W){1'b0}}, cur.penalty_ms};
	assign good_bad_mode = bad_rtt ? '0 : good_inc;

	always_comb begin
		nxt = cur;
		if (cur.mode_good) begin
			if (bad_rtt) begin
				nxt.mode_good      = 1'b0;
				nxt.good_time_ms   = '0;
				nxt.reduce_time_ms = '0;
				// short good spell: back off harder
				if ((cur.good_time_ms < hold_w) && (cur.penalty_ms < cfg.penalty_max_ms)) begin
					nxt.penalty_ms = (dbl > {1'b0, cfg.penalty_max_ms}) ?
						cfg.penalty_max_ms : dbl[TIME_W-1:0];
				end
			end else begin
				nxt.good_time_ms   = good_inc;
				nxt.reduce_time_ms = red_inc;
				if ((red_inc > hold_w) && (cur.penalty_ms > cfg.penalty_min_ms)) begin
					nxt.penalty_ms     = (half < cfg.penalty_min_ms) ? cfg.penalty_min_ms : half;
					nxt.reduce_time_ms = '0;
				end
			end
		end else begin
			nxt.good_time_ms = good_bad_mode;
			if (good_bad_mode > pen_w) begin
				nxt.mode_good      = 1'b1;
				nxt.good_time_ms   = '0;
				nxt.reduce_time_ms = '0;
			end
		end
	end

endmodule

### src/rtt_flow_control_mode.sv
// rtt_flow_control_mode: top level of the good/bad mode flow controller.
// Depends on rttfc_pkg, rttfc_if and rttfc_core.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+---------------------------------
//   tick    | in  | valid / ready | tick_ms[15:0], rtt_ms[15:0]
//   res     | out | valid / ready | good_mode, send_rate[7:0]
//   cfg     | in  | valid / ready | index[2:0], data[15:0]
//
// One item per cycle sustained unless res stalls; each item passes the input
// register, then one state update (32-bit saturating add and compare) to res.
// Input register and result register decouple the two sides: a tick is taken
// while a result waits, and only a stall with both stages full drops tick.ready.
// Reset: state, config and valid flags take their reset values; ready stays low
// during reset and straight after it, until live_q is set.
`timescale 1ns / 1ps
module rtt_flow_control_mode (
	input logic         clk,
	input logic         arst_n,
	rttfc_tick_if.sink  tick,
	rttfc_res_if.source res,
	rttfc_cfg_if.sink   cfg
);
	import rttfc_pkg::*;

	logic              live_q;      // out of reset
	logic              valid_s1;
	logic [TIME_W-1:0] tick_s1;
	logic [TIME_W-1:0] rtt_s1;
	logic              adv;         // stage 1 item moves into result register
	logic              res_valid_q;
	logic              good_mode_q;
	logic [RATE_W-1:0] send_rate_q;
	cfg_t              cfg_q;
	state_t            state_q;
	state_t            state_nxt;

	assign adv        = valid_s1 && (!res_valid_q || res.ready);
	assign tick.ready = live_q && (!valid_s1 || adv);
	assign cfg.ready  = live_q;

	assign res.valid     = res_valid_q;
	assign res.good_mode = good_mode_q;
	assign res.send_rate = send_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
		end
	end

	// registers; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rtt_threshold_ms   <= RST_RTT_THRESHOLD;
			cfg_q.good_rate          <= RST_GOOD_RATE;
			cfg_q.bad_rate           <= RST_BAD_RATE;
			cfg_q.penalty_initial_ms <= RST_PENALTY_INITIAL;
			cfg_q.penalty_min_ms     <= RST_PENALTY_MIN;
			cfg_q.penalty_max_ms     <= RST_PENALTY_MAX;
			cfg_q.hold_ms            <= RST_HOLD;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RTT_THRESHOLD:   cfg_q.rtt_threshold_ms   <= cfg.data;
				REG_GOOD_RATE:       cfg_q.good_rate          <= cfg.data[RATE_W-1:0];
				REG_BAD_RATE:        cfg_q.bad_rate           <= cfg.data[RATE_W-1:0];
				REG_PENALTY_INITIAL: cfg_q.penalty_initial_ms <= cfg.data;
				REG_PENALTY_MIN:     cfg_q.penalty_min_ms     <= cfg.data;
				REG_PENALTY_MAX:     cfg_q.penalty_max_ms     <= cfg.data;
				REG_HOLD:            cfg_q.hold_ms            <= cfg.data;
				default:             ;  // unmapped index, dropped
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.tick_ms;
			rtt_s1  <= tick.rtt_ms;
		end
	end

	rttfc_core u_core (
		.cfg     (cfg_q),
		.cur     (state_q),
		.tick_ms (tick_s1),
		.rtt_ms  (rtt_s1),
		.nxt     (state_nxt)
	);

	// flow state moves once per item, as it leaves stage 1.
	// On reset the penalty restarts from the reset value of the initial penalty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode_good      <= 1'b0;
			state_q.penalty_ms     <= RST_PENALTY_INITIAL;
			state_q.good_time_ms   <= '0;
			state_q.reduce_time_ms <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			good_mode_q <= state_nxt.mode_good;
			send_rate_q <= state_nxt.mode_good ? cfg_q.good_rate : cfg_q.bad_rate;
		end
	end

endmodule

### src/rttfc_checker.sv
// rttfc_checker: port-level assertions for rtt_flow_control_mode, attached by bind.
// Depends on rttfc_pkg and rtt_flow_control_mode.
`timescale 1ns / 1ps
module rttfc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tick_valid,
	input logic                         tick_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_good_mode,
	input logic [rttfc_pkg::RATE_W-1:0] res_send_rate
);
	import rttfc_pkg::*;

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_good_mode) &&
			$stable(res_send_rate))
		else $error("result changed while stalled");

	// item taken under a stall fills stage 1, so a continuing stall blocks input
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready && $past(res_valid && !res_ready) &&
			$past(tick_valid && tick_ready) |-> !tick_ready)
		else $error("input accepted with both stages full");

	// a result appears only after its item has passed the input stage and the result register
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(tick_valid && tick_ready, 2))
		else $error("result with no accepted item");

	// ready held low straight out of reset
	a_ready_after_rst: assert property (@(posedge clk)
		!$past(arst_n) && arst_n |-> !tick_ready)
		else $error("input ready straight out of reset");

endmodule

bind rtt_flow_control_mode rttfc_checker u_rttfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tick_valid    (tick.valid),
	.tick_ready    (tick.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_good_mode (res.good_mode),
	.res_send_rate (res.send_rate)
);
